// File: rtl/upsc_pkg.sv
// ----------------------------------------------------------------------------
// upsc_pkg
// Shared types, register indexes and the averaging function of the 2x
// upscaler with slice blend.
// ----------------------------------------------------------------------------
`default_nettype none

package upsc_pkg;

  // Pixel and coordinate widths of the stream fields
  localparam int PIX_W   = 16;
  localparam int COORD_W = 11;
  localparam int CFG_W   = 11;
  // Wide enough for a clamped frame dimension up to 4096
  localparam int DIM_W   = 13;

  typedef logic signed [PIX_W-1:0] pixel_t;
  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic [CFG_W-1:0]        cfg_data_t;
  typedef logic [1:0]              cfg_index_t;
  typedef logic [DIM_W-1:0]        dim_t;

  // Configuration register indexes
  localparam cfg_index_t REG_FRAME_WIDTH  = 2'd0;
  localparam cfg_index_t REG_FRAME_HEIGHT = 2'd1;
  localparam cfg_index_t REG_BLEND_SLICES = 2'd2;

  // Input action codes
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Reset values of the size registers
  localparam cfg_data_t FRAME_DIM_RESET = 11'd512;

  // One 2x2 output block: doubled base coordinates and the four operands.
  // Result k of the block is avg(p, operand k), operand 0 being p itself.
  typedef struct packed {
    coord_t ox;
    coord_t oy;
    pixel_t p;
    pixel_t right;
    pixel_t below;
    pixel_t diag;
  } blk_t;

  // Work handed from the pixel pipeline to the result sequencer
  typedef struct packed {
    logic          two;
    blk_t [1:0]    blks;
  } job_t;

  // Half of the exact sum, truncated toward zero
  function automatic pixel_t avg2(input pixel_t a, input pixel_t b);
    logic signed [PIX_W:0] sum;
    logic signed [PIX_W:0] adj;
    sum = {a[PIX_W-1], a} + {b[PIX_W-1], b};
    adj = sum + {{PIX_W{1'b0}}, sum[PIX_W]};
    return adj[PIX_W:1];
  endfunction

endpackage

`default_nettype wire

// File: rtl/upsc_in_if.sv
// ----------------------------------------------------------------------------
// upsc_in_if
// Input stream channel: source pixels and flush requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface upsc_in_if;
  import upsc_pkg::*;

  logic   valid;
  logic   ready;
  logic   action;
  pixel_t pixel_a;
  pixel_t pixel_b;

  modport source (output valid, output action, output pixel_a, output pixel_b,
                  input ready);
  modport sink (input valid, input action, input pixel_a, input pixel_b,
                output ready);
endinterface

`default_nettype wire

// File: rtl/upsc_out_if.sv
// ----------------------------------------------------------------------------
// upsc_out_if
// Output stream channel: upscaled pixels with their coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface upsc_out_if;
  import upsc_pkg::*;

  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  pixel_t out_value;
  logic   last;

  modport source (output valid, output out_x, output out_y, output out_value,
                  output last, input ready);
  modport sink (input valid, input out_x, input out_y, input out_value,
                input last, output ready);
endinterface

`default_nettype wire

// File: rtl/image_2x_upscale_with_slice_blend.sv
// ----------------------------------------------------------------------------
// image_2x_upscale_with_slice_blend
// Doubles a signed 16-bit raster image by neighbor averaging, with an
// optional blend of two slices ahead of the upscale.
// ----------------------------------------------------------------------------
// Usage: the block gives one result per cycle while the output is ready, from
// a single output register, so a source pixel yields zero, one or two blocks
// of four results and a flush item one block. Input is taken every cycle as
// long as the result sequencer can take the pending job; one pixel sits in
// the registered read stage of the line and first-row memories while the
// previous job drains. Each pixel emits the block up-left of it once its
// neighbors are in; after the last pixel of a frame, one flush item per
// column emits the bottom row, wrapping to the stored first row. A pixel
// sent while flushing starts a new frame. Writing any of the three registers
// restarts the frame; write only while the block is idle. Sizes are clamped
// to 2..MAX_WIDTH and 2..MAX_HEIGHT. Memories need no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module image_2x_upscale_with_slice_blend #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire upsc_pkg::cfg_index_t   cfg_index,
  input  wire upsc_pkg::cfg_data_t    cfg_data,
  upsc_in_if.sink                     pix_in,
  upsc_out_if.source                  pix_out
);
  import upsc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam dim_t MAXW = DIM_W'(MAX_WIDTH);
  localparam dim_t MAXH = DIM_W'(MAX_HEIGHT);
  localparam dim_t MIN_DIM = DIM_W'(2);

  // Configuration
  cfg_data_t frame_width;
  cfg_data_t frame_height;
  logic      blend_slices;

  // Frame position
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] flush_column;
  logic          draining;

  // Read stage
  logic          b_valid;
  logic          b_flush;
  logic          b_main;
  logic          b_edge;
  logic          b_col0;
  pixel_t        b_v;
  logic [CW-1:0] b_bx0;
  logic [CW-1:0] b_bx1;
  logic [RW-1:0] b_by;

  // Neighbor registers
  pixel_t left_pixel;
  pixel_t upper_left_pixel;
  pixel_t row_start_prev;
  pixel_t row_start_cur;

  dim_t          fw;
  dim_t          fh;
  dim_t          eff_w;
  dim_t          eff_h;
  dim_t          w_last;
  dim_t          h_last;
  logic          in_acc;
  logic          pix_acc;
  logic          flush_acc;
  logic          x_end;
  logic          y_end;
  logic          c_end;
  logic [CW-1:0] c_next;
  pixel_t        src_v;

  logic   b_has_job;
  logic   b_fire;
  logic   job_free;
  job_t   job;

  pixel_t line_rd_a;
  pixel_t line_rd_b;
  pixel_t first_rd_a;
  pixel_t first_rd_b;
  logic [CW-1:0] line_raddr_a;

  // Clamp the frame size
  always_comb begin
    fw = DIM_W'(frame_width);
    fh = DIM_W'(frame_height);
    if (fw < MIN_DIM) begin
      eff_w = MIN_DIM;
    end else if (fw > MAXW) begin
      eff_w = MAXW;
    end else begin
      eff_w = fw;
    end
    if (fh < MIN_DIM) begin
      eff_h = MIN_DIM;
    end else if (fh > MAXH) begin
      eff_h = MAXH;
    end else begin
      eff_h = fh;
    end
  end

  assign w_last = eff_w - DIM_W'(1);
  assign h_last = eff_h - DIM_W'(1);

  // Input transaction decode
  assign b_has_job = b_flush || b_main;
  assign b_fire    = b_valid && (job_free || !b_has_job);
  assign pix_in.ready = !b_valid || b_fire;
  assign in_acc    = pix_in.valid && pix_in.ready;
  assign pix_acc   = in_acc && (pix_in.action == ACT_PIXEL);
  assign flush_acc = in_acc && (pix_in.action == ACT_FLUSH) && draining;

  assign x_end  = (DIM_W'(column_count) == w_last);
  assign y_end  = (DIM_W'(row_count) == h_last);
  assign c_end  = (DIM_W'(flush_column) == w_last);
  assign c_next = c_end ? '0 : flush_column + CW'(1);
  assign src_v  = blend_slices ? avg2(pix_in.pixel_a, pix_in.pixel_b) : pix_in.pixel_a;
  assign line_raddr_a = pix_acc ? column_count : flush_column;

  // Configuration writes and frame sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_DIM_RESET;
      frame_height <= FRAME_DIM_RESET;
      blend_slices <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
      flush_column <= '0;
      draining     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_BLEND_SLICES: blend_slices <= cfg_data[0];
        default: ;
      endcase
      if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT ||
          cfg_index == REG_BLEND_SLICES) begin
        column_count <= '0;
        row_count    <= '0;
        flush_column <= '0;
        draining     <= 1'b0;
      end
    end else if (pix_acc) begin
      flush_column <= '0;
      if (x_end) begin
        column_count <= '0;
        if (y_end) begin
          row_count <= '0;
          draining  <= 1'b1;
        end else begin
          row_count <= row_count + RW'(1);
          draining  <= 1'b0;
        end
      end else begin
        column_count <= column_count + CW'(1);
        draining     <= 1'b0;
      end
    end else if (flush_acc) begin
      flush_column <= c_next;
      if (c_end) begin
        draining <= 1'b0;
      end
    end
  end

  // Read stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pix_acc || flush_acc) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  // Read stage payload: block positions and what the item emits
  always_ff @(posedge clk) begin
    if (pix_acc || flush_acc) begin
      b_flush <= flush_acc;
      b_v     <= src_v;
      if (flush_acc) begin
        b_main <= 1'b0;
        b_edge <= 1'b0;
        b_col0 <= 1'b0;
        b_bx0  <= flush_column;
        b_bx1  <= flush_column;
        b_by   <= h_last[RW-1:0];
      end else begin
        b_main <= (row_count != '0) && (column_count != '0);
        b_edge <= (row_count != '0) && x_end;
        b_col0 <= (column_count == '0);
        b_bx0  <= column_count - CW'(1);
        b_bx1  <= column_count;
        b_by   <= row_count - RW'(1);
      end
    end
  end

  // Line store: latest row, read above the current pixel or for the flush
  upsc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk     (clk),
    .we      (pix_acc),
    .waddr   (column_count),
    .wdata   (src_v),
    .re      (pix_acc || flush_acc),
    .raddr_a (line_raddr_a),
    .raddr_b (c_next),
    .rdata_a (line_rd_a),
    .rdata_b (line_rd_b)
  );

  // First row store: wraps the bottom row onto row 0
  upsc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_first_ram (
    .clk     (clk),
    .we      (pix_acc && (row_count == '0)),
    .waddr   (column_count),
    .wdata   (src_v),
    .re      (flush_acc),
    .raddr_a (flush_column),
    .raddr_b (c_next),
    .rdata_a (first_rd_a),
    .rdata_b (first_rd_b)
  );

  // Assemble the job from read data and neighbor registers
  always_comb begin
    job.two = b_edge;
    job.blks[0].ox = COORD_W'({b_bx0, 1'b0});
    job.blks[0].oy = COORD_W'({b_by, 1'b0});
    job.blks[1].ox = COORD_W'({b_bx1, 1'b0});
    job.blks[1].oy = COORD_W'({b_by, 1'b0});
    job.blks[1].p     = line_rd_a;
    job.blks[1].right = row_start_prev;
    job.blks[1].below = b_v;
    job.blks[1].diag  = row_start_cur;
    if (b_flush) begin
      job.blks[0].p     = line_rd_a;
      job.blks[0].right = line_rd_b;
      job.blks[0].below = first_rd_a;
      job.blks[0].diag  = first_rd_b;
    end else begin
      job.blks[0].p     = upper_left_pixel;
      job.blks[0].right = line_rd_a;
      job.blks[0].below = left_pixel;
      job.blks[0].diag  = b_v;
    end
  end

  // Advance the neighbor registers as each pixel leaves the read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
      row_start_prev   <= '0;
      row_start_cur    <= '0;
    end else if (b_fire && !b_flush) begin
      left_pixel       <= b_v;
      upper_left_pixel <= line_rd_a;
      if (b_col0) begin
        row_start_prev <= line_rd_a;
        row_start_cur  <= b_v;
      end
    end
  end

  upsc_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .job_load (b_fire && b_has_job),
    .job_in   (job),
    .job_free (job_free),
    .pix_out  (pix_out)
  );

endmodule

`default_nettype wire

// File: rtl/upsc_ram.sv
// ----------------------------------------------------------------------------
// upsc_ram
// Generic synchronous RAM: one write port, two read ports, registered read
// data (old contents on a same-address write).
// ----------------------------------------------------------------------------
`default_nettype none

module upsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// File: rtl/upsc_emit.sv
// ----------------------------------------------------------------------------
// upsc_emit
// Result sequencer: walks the one or two 2x2 blocks of a job, averages one
// operand pair per cycle unless stalled and puts it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module upsc_emit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_load,
  input  wire upsc_pkg::job_t  job_in,
  output logic                 job_free,
  upsc_out_if.source           pix_out
);
  import upsc_pkg::*;

  logic       job_valid;
  job_t       job;
  logic [2:0] idx;

  blk_t       cur;
  pixel_t     other;
  logic       step_last;
  logic       out_load;

  // Select the block and operand of this step
  always_comb begin
    cur = job.blks[idx[2]];
    case (idx[1:0])
      2'd0:    other = cur.p;
      2'd1:    other = cur.right;
      2'd2:    other = cur.below;
      2'd3:    other = cur.diag;
      default: other = cur.p;
    endcase
  end

  assign step_last = (idx[1:0] == 2'b11) && (idx[2] || !job.two);
  assign out_load  = job_valid && (!pix_out.valid || pix_out.ready);
  assign job_free  = !job_valid || (out_load && step_last);

  // Advance through the job and accept the next one
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (job_load) begin
      job_valid <= 1'b1;
      idx       <= 3'd0;
    end else if (out_load) begin
      if (step_last) begin
        job_valid <= 1'b0;
        idx       <= 3'd0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  // Hold the job payload
  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_in;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (out_load) begin
      pix_out.valid <= 1'b1;
    end else if (pix_out.ready) begin
      pix_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pix_out.out_x     <= cur.ox | {{(COORD_W-1){1'b0}}, idx[0]};
      pix_out.out_y     <= cur.oy | {{(COORD_W-1){1'b0}}, idx[1]};
      pix_out.out_value <= avg2(cur.p, other);
      pix_out.last      <= step_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/upsc_check.sv
// ----------------------------------------------------------------------------
// upsc_check
// Port-level checks of the upscaler output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module upsc_check (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire upsc_pkg::coord_t    out_x,
  input wire upsc_pkg::coord_t    out_y,
  input wire upsc_pkg::pixel_t    out_value,
  input wire logic                out_last
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

  // Drop output valid after reset
  a_out_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A block ends on its down-right pixel
  a_last_odd: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_x[0] && out_y[0])
    else $error("last result not at odd coordinates");

  // An accepted block origin is not directly followed by a last result at an even column
  a_origin_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_x[0] && !out_y[0] |=>
      !(out_valid && out_last && !out_x[0]))
    else $error("block order broken");

endmodule

bind image_2x_upscale_with_slice_blend upsc_check u_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_x     (pix_out.out_x),
  .out_y     (pix_out.out_y),
  .out_value (pix_out.out_value),
  .out_last  (pix_out.last)
);

`default_nettype wire
